// File: src/fgr_pkg.sv
// Shared types, glyph table and pixel index helpers for the 5x5 glyph rasterizer.
package fgr_pkg;

  localparam int unsigned GlyphSize = 5;
  localparam int unsigned GlyphBits = GlyphSize * GlyphSize;
  localparam int unsigned IdxW      = $clog2(GlyphBits);
  localparam int unsigned OffW      = $clog2(GlyphSize);
  localparam int unsigned CoordW    = 10;
  localparam int unsigned PixW      = 11;
  localparam int unsigned ColorW    = 16;

  typedef logic [GlyphBits-1:0] mask_t;

  typedef struct packed {
    mask_t             mask;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              buf_sel;
  } item_t;

  typedef struct packed {
    logic [OffW-1:0] col;
    logic [OffW-1:0] row;
  } offs_t;

  // bit (i*5 + j) holds row j of column i
  function automatic mask_t cols5(input logic [4:0] c0, input logic [4:0] c1,
                                  input logic [4:0] c2, input logic [4:0] c3,
                                  input logic [4:0] c4);
    cols5 = {c4, c3, c2, c1, c0};
  endfunction

  function automatic mask_t glyph_mask(input logic [7:0] code);
    mask_t m;
    unique case (code)
      8'h20: m = '0;
      8'h61: m = cols5(5'h1E, 5'h05, 5'h05, 5'h05, 5'h1E);
      8'h62: m = cols5(5'h1F, 5'h15, 5'h15, 5'h15, 5'h0C);
      8'h63: m = cols5(5'h0E, 5'h11, 5'h11, 5'h11, 5'h11);
      8'h64: m = cols5(5'h1F, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h65: m = cols5(5'h1F, 5'h15, 5'h15, 5'h15, 5'h15);
      8'h66: m = cols5(5'h1F, 5'h05, 5'h05, 5'h01, 5'h01);
      8'h67: m = cols5(5'h0E, 5'h11, 5'h15, 5'h15, 5'h1D);
      8'h68: m = cols5(5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F);
      8'h69: m = cols5(5'h11, 5'h11, 5'h1F, 5'h11, 5'h11);
      8'h6A: m = cols5(5'h08, 5'h10, 5'h11, 5'h11, 5'h0F);
      8'h6B: m = cols5(5'h1F, 5'h04, 5'h06, 5'h05, 5'h18);
      8'h6C: m = cols5(5'h1F, 5'h10, 5'h10, 5'h10, 5'h10);
      8'h6D: m = cols5(5'h1F, 5'h02, 5'h04, 5'h02, 5'h1F);
      8'h6E: m = cols5(5'h1F, 5'h01, 5'h0E, 5'h10, 5'h1F);
      8'h6F: m = cols5(5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E);
      8'h70: m = cols5(5'h1F, 5'h05, 5'h05, 5'h05, 5'h02);
      8'h71: m = cols5(5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10);
      8'h72: m = cols5(5'h1F, 5'h05, 5'h05, 5'h0D, 5'h12);
      8'h73: m = cols5(5'h12, 5'h15, 5'h15, 5'h15, 5'h09);
      8'h74: m = cols5(5'h01, 5'h01, 5'h1F, 5'h01, 5'h01);
      8'h75: m = cols5(5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E);
      8'h76: m = cols5(5'h03, 5'h0C, 5'h10, 5'h0C, 5'h03);
      8'h77: m = cols5(5'h1F, 5'h08, 5'h04, 5'h08, 5'h1F);
      8'h78: m = cols5(5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11);
      8'h79: m = cols5(5'h03, 5'h04, 5'h1C, 5'h04, 5'h03);
      8'h7A: m = cols5(5'h19, 5'h15, 5'h15, 5'h15, 5'h13);
      8'h2D: m = cols5(5'h04, 5'h04, 5'h04, 5'h04, 5'h04);
      8'h30: m = cols5(5'h0E, 5'h13, 5'h15, 5'h19, 5'h0E);
      8'h31: m = cols5(5'h10, 5'h12, 5'h1F, 5'h10, 5'h10);
      8'h32: m = cols5(5'h12, 5'h19, 5'h15, 5'h12, 5'h00);
      8'h33: m = cols5(5'h0A, 5'h11, 5'h15, 5'h15, 5'h0A);
      8'h34: m = cols5(5'h07, 5'h04, 5'h04, 5'h1F, 5'h04);
      8'h35: m = cols5(5'h17, 5'h15, 5'h15, 5'h09, 5'h00);
      8'h36: m = cols5(5'h0E, 5'h15, 5'h15, 5'h15, 5'h08);
      8'h37: m = cols5(5'h01, 5'h01, 5'h1D, 5'h03, 5'h01);
      8'h38: m = cols5(5'h0A, 5'h15, 5'h15, 5'h15, 5'h0A);
      8'h39: m = cols5(5'h02, 5'h15, 5'h15, 5'h15, 5'h0E);
      default: m = '1;
    endcase
    glyph_mask = m;
  endfunction

  // index of the lowest set bit
  function automatic logic [IdxW-1:0] low_index(input mask_t m);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int k = GlyphBits - 1; k >= 0; k--) begin
      if (m[k]) idx = IdxW'(k);
    end
    low_index = idx;
  endfunction

  // split a bit index into column and row offsets
  function automatic offs_t split_index(input logic [IdxW-1:0] idx);
    offs_t o;
    logic [IdxW-1:0] base;
    priority if (idx >= IdxW'(4 * GlyphSize)) begin
      o.col = OffW'(4);
    end else if (idx >= IdxW'(3 * GlyphSize)) begin
      o.col = OffW'(3);
    end else if (idx >= IdxW'(2 * GlyphSize)) begin
      o.col = OffW'(2);
    end else if (idx >= IdxW'(GlyphSize)) begin
      o.col = OffW'(1);
    end else begin
      o.col = OffW'(0);
    end
    base  = IdxW'(o.col) * IdxW'(GlyphSize);
    o.row = OffW'(idx - base);
    split_index = o;
  endfunction

endpackage

// File: src/font_glyph_rasterizer_5x5.sv
// Top level of the 5x5 bitmap font glyph rasterizer.
// A request passes the front register, the queue and the back glyph register
// before its first pixel leaves. Throughput: one pixel per cycle at the output
// register unless out_ready_i stalls; a glyph has 1 to 25 lit bits, a blank none.
// The back stage's bit walk sets the rate; a two-entry queue decouples it.
// Reset clears all valid flags and the bit walk; data registers are not reset.
module font_glyph_rasterizer_5x5 import fgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic [CoordW-1:0] origin_x_i,
  input  logic [CoordW-1:0] origin_y_i,
  input  logic [ColorW-1:0] color_i,
  input  logic              buffer_select_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixW-1:0]   pixel_x_o,
  output logic [PixW-1:0]   pixel_y_o,
  output logic [ColorW-1:0] out_color_o,
  output logic              out_buffer_o,
  output logic              last_o
);

  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  fgr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_code_i,
    .origin_x_i,
    .origin_y_i,
    .color_i,
    .buffer_select_i,
    .f_valid_o (f_valid),
    .f_ready_i (f_ready),
    .f_item_o  (f_item)
  );

  fgr_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_item_i  (f_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  fgr_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .out_valid_o,
    .out_ready_i,
    .pixel_x_o,
    .pixel_y_o,
    .out_color_o,
    .out_buffer_o,
    .last_o
  );

endmodule

// File: src/fgr_front.sv
// Front stage: accepts requests, looks up the glyph and drops blank glyphs.
module fgr_front import fgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic [CoordW-1:0] origin_x_i,
  input  logic [CoordW-1:0] origin_y_i,
  input  logic [ColorW-1:0] color_i,
  input  logic              buffer_select_i,
  output logic              f_valid_o,
  input  logic              f_ready_i,
  output item_t             f_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  mask_t mask;

  assign in_ready_o = !valid_q || f_ready_i;
  assign mask       = glyph_mask(char_code_i);

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (f_ready_i) valid_d = 1'b0;
    if (in_valid_i && in_ready_o) begin
      valid_d        = (mask != '0);
      item_d.mask    = mask;
      item_d.x       = origin_x_i;
      item_d.y       = origin_y_i;
      item_d.color   = color_i;
      item_d.buf_sel = buffer_select_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign f_valid_o = valid_q;
  assign f_item_o  = item_q;

endmodule

// File: src/fgr_queue.sv
// Two-entry queue of decoded glyph requests between front and back.
module fgr_queue import fgr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output item_t rd_item_o
);

  item_t      mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, wp_d, rp_q, rp_d;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = pop ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wp_q  <= wp_d;
      rp_q  <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_item_i;
  end

endmodule

// File: src/fgr_back.sv
// Back stage: walks the lit bits of one glyph and emits one pixel per cycle unless the output stalls.
module fgr_back import fgr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  item_t             q_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixW-1:0]   pixel_x_o,
  output logic [PixW-1:0]   pixel_y_o,
  output logic [ColorW-1:0] out_color_o,
  output logic              out_buffer_o,
  output logic              last_o
);

  item_t             cur_q, cur_d;
  logic              ov_q, ov_d;
  logic [PixW-1:0]   px_q, px_d, py_q, py_d;
  logic [ColorW-1:0] oc_q, oc_d;
  logic              ob_q, ob_d, ol_q, ol_d;
  logic              busy, emit, load;
  mask_t             rest;
  offs_t             offs;

  assign busy = (cur_q.mask != '0);
  assign emit = busy && (!ov_q || out_ready_i);
  assign rest = cur_q.mask & (cur_q.mask - mask_t'(1));
  assign offs = split_index(low_index(cur_q.mask));
  assign load = q_valid_i && (!busy || (emit && rest == '0));
  assign q_ready_o = load;

  always_comb begin
    cur_d = cur_q;
    ov_d  = ov_q && !out_ready_i;
    px_d  = px_q;
    py_d  = py_q;
    oc_d  = oc_q;
    ob_d  = ob_q;
    ol_d  = ol_q;
    if (emit) begin
      cur_d.mask = rest;
      ov_d       = 1'b1;
      px_d       = PixW'(cur_q.x) + PixW'(offs.col);
      py_d       = PixW'(cur_q.y) + PixW'(offs.row);
      oc_d       = cur_q.color;
      ob_d       = cur_q.buf_sel;
      ol_d       = (rest == '0);
    end
    if (load) cur_d = q_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      cur_q <= cur_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q          <= px_d;
    py_q          <= py_d;
    oc_q          <= oc_d;
    ob_q          <= ob_d;
    ol_q          <= ol_d;
  end

  assign out_valid_o  = ov_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign out_color_o  = oc_q;
  assign out_buffer_o = ob_q;
  assign last_o       = ol_q;

endmodule
